### src/pcp_pkg.sv
`default_nettype none
package pcp_pkg;

  localparam int unsigned MaxItems = 1024;
  localparam int unsigned PosW     = $clog2(MaxItems);
  localparam int unsigned CntW     = PosW + 1;

  localparam int unsigned ValW = 32;
  localparam int unsigned DvdW = ValW - 1;
  localparam int unsigned DsrW = 16;
  localparam int unsigned SqW  = 32;
  localparam int unsigned StepW = $clog2(DvdW);

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DsrW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage
`default_nettype wire

### src/pcp_rem_unit.sv
`default_nettype none
module pcp_rem_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pcp_pkg::rem_req_t req_i,
  output pcp_pkg::rem_rsp_t      rsp_o
);
  import pcp_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DsrW-1:0] rem_q, rem_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DsrW-1:0] dsr_q, dsr_d;
  logic [DsrW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, dvd_q[DvdW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // one restoring step per cycle
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = DsrW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[DsrW-1:0];
      end
      dvd_d  = {dvd_q[DvdW-2:0], 1'b0};
      step_d = StepW'(step_q + 1'b1);
      if (step_q == StepW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule
`default_nettype wire

### src/prime_count_and_positions.sv
`default_nettype none
// Primality test of a stream of signed 32-bit elements by trial division,
// with element position and running prime count per array (reset after the
// item marked last; position saturates at 1023, count at 1024). One item is
// in work at a time. Values below 2, even values and 2, 3, 5 are decided on
// acceptance and go straight to the output state. Odd values alternate a
// compare state with a run of the bit-serial remainder unit for every odd
// divisor tried from 3 up to the square root. The result sits in an output
// register; a new item is taken once the previous one is handed to it.
module prime_count_and_positions (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [31:0]        value_i,
  input  wire logic                      last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic                           is_prime_o,
  output logic [pcp_pkg::PosW-1:0]       position_o,
  output logic [pcp_pkg::CntW-1:0]       prime_count_o,
  output logic                           final_res_o
);
  import pcp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [DvdW-1:0] x_q, x_d;
  logic            last_q, last_d;
  logic            prime_q, prime_d;
  logic [DsrW-1:0] d_q, d_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic [PosW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic            oprime_q, oprime_d;
  logic [PosW-1:0] opos_q, opos_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;
  logic            olast_q, olast_d;
  logic [CntW-1:0] cnt_new;
  logic            sq_over;
  rem_req_t        req;
  rem_rsp_t        rsp;

  pcp_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign sq_over      = sq_q > {1'b0, x_q};
  assign req.start    = (state_q == S_CHECK) && !sq_over;
  assign req.dividend = x_q;
  assign req.divisor  = d_q;

  assign cnt_new = (prime_q && cnt_q < CntW'(MaxItems)) ? CntW'(cnt_q + 1'b1) : cnt_q;

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    last_d   = last_q;
    prime_d  = prime_q;
    d_d      = d_q;
    sq_d     = sq_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oprime_d = oprime_q;
    opos_d   = opos_q;
    ocnt_d   = ocnt_q;
    olast_d  = olast_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d    = value_i[DvdW-1:0];
          last_d = last_i;
          d_d    = DsrW'(3);
          sq_d   = SqW'(9);
          state_d = S_OUT;
          priority if (value_i <= 32'sd1) begin
            prime_d = 1'b0;
          end else if (value_i == 32'sd2 || value_i == 32'sd3 || value_i == 32'sd5) begin
            prime_d = 1'b1;
          end else if (!value_i[0]) begin
            prime_d = 1'b0;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sq_over) begin
          prime_d = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          if (rsp.zero) begin
            prime_d = 1'b0;
            state_d = S_OUT;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            sq_d    = SqW'(sq_q + {d_q, 2'b00} + SqW'(4));
            d_d     = DsrW'(d_q + DsrW'(2));
            state_d = S_CHECK;
          end
        end
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oprime_d = prime_q;
          opos_d   = idx_q;
          ocnt_d   = cnt_new;
          olast_d  = last_q;
          if (last_q) begin
            idx_d = '0;
            cnt_d = '0;
          end else begin
            cnt_d = cnt_new;
            if (idx_q < PosW'(MaxItems - 1)) begin
              idx_d = PosW'(idx_q + 1'b1);
            end
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    last_q   <= last_d;
    prime_q  <= prime_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    oprime_q <= oprime_d;
    opos_q   <= opos_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ovalid_q;
  assign is_prime_o    = oprime_q;
  assign position_o    = opos_q;
  assign prime_count_o = ocnt_q;
  assign final_res_o   = olast_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == S_DIV)
    else $error("remainder done outside divide state");

  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_CHECK) |-> d_q[0])
    else $error("trial divisor even");

  a_prime_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_prime_o) |-> prime_count_o != '0)
    else $error("prime reported with zero count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxItems))
    else $error("prime count beyond limit");

endmodule
`default_nettype wire
